### hdl/rgb_to_hsl_converter_defines.svh
// Assertion macros used by the checker module.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RGB2HSL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb2hsl: same-cycle check failed");

// Next-cycle implication.
`define RGB2HSL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb2hsl: next-cycle check failed");

`endif

### hdl/rgb2hsl_pkg.sv
package rgb2hsl_pkg;

	localparam int COMP_W    = 8;
	localparam int QUOT_W    = 8;
	localparam int POS_W     = $clog2(QUOT_W);
	localparam int NUM_W     = 11;
	localparam int HUE_DIV_W = 11;
	localparam int HUE_REM_W = 19;
	localparam int SAT_DIV_W = 8;
	localparam int SAT_REM_W = 16;

	// Which component holds the maximum; red wins ties over green, green over blue.
	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} max_sel_t;

	// One word in flight through the divider stages.
	typedef struct packed {
		logic [HUE_REM_W-1:0] hue_rem;
		logic [HUE_DIV_W-1:0] hue_div;
		logic [QUOT_W-1:0]    hue_q;
		logic [SAT_REM_W-1:0] sat_rem;
		logic [SAT_DIV_W-1:0] sat_div;
		logic [QUOT_W-1:0]    sat_q;
		logic [COMP_W-1:0]    lightness;
	} div_word_t;

endpackage

### hdl/rgb_to_hsl_converter.sv
// A pixel taken at a clock edge passes through six stages, the first loaded at the taking edge,
// and its result shows on the outputs while stage 6 holds it. Throughput: one pixel per cycle
// unless stalled; each stage holds one word and fills bubbles under stall.
// The eight-bit hue and saturation divisions take two restoring steps per stage.
// Reset: arst_n low clears every stage valid bit at once; payload registers keep no reset.
module rgb_to_hsl_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [rgb2hsl_pkg::COMP_W-1:0] red,
	input  logic [rgb2hsl_pkg::COMP_W-1:0] green,
	input  logic [rgb2hsl_pkg::COMP_W-1:0] blue,
	output logic                           hsl_valid,
	input  logic                           hsl_stall,
	output logic [rgb2hsl_pkg::COMP_W-1:0] hue,
	output logic [rgb2hsl_pkg::COMP_W-1:0] saturation,
	output logic [rgb2hsl_pkg::COMP_W-1:0] lightness
);
	import rgb2hsl_pkg::*;

	// Front end: stage 1 finds max, min and which channel wins; stage 2 forms
	// delta, the saturation denominator, the hue numerator and the 255x dividends.
	logic      mid_valid;
	logic      mid_stall;
	div_word_t mid_word;
	div_word_t result;

	rgb2hsl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.word_valid  (mid_valid),
		.word_stall  (mid_stall),
		.word        (mid_word)
	);

	// Back end: stages 3 to 6 run both divisions side by side, lightness rides along.
	// Stage 6 doubles as the output register; a stall there holds the word
	// while earlier stages keep filling any empty slots.
	rgb2hsl_divider u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (mid_valid),
		.word_stall (mid_stall),
		.word       (mid_word),
		.hsl_valid  (hsl_valid),
		.hsl_stall  (hsl_stall),
		.result     (result)
	);

	assign hue        = result.hue_q;
	assign saturation = result.sat_q;
	assign lightness  = result.lightness;

endmodule

### hdl/rgb2hsl_front.sv
module rgb2hsl_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic [rgb2hsl_pkg::COMP_W-1:0]  red,
	input  logic [rgb2hsl_pkg::COMP_W-1:0]  green,
	input  logic [rgb2hsl_pkg::COMP_W-1:0]  blue,
	output logic                            word_valid,
	input  logic                            word_stall,
	output rgb2hsl_pkg::div_word_t          word
);
	import rgb2hsl_pkg::*;

	logic              valid_s1, valid_s2;
	logic              stall_s1, stall_s2;
	logic [COMP_W-1:0] red_s1, green_s1, blue_s1, mx_s1, mn_s1;
	max_sel_t          sel_s1;
	div_word_t         word_s2;

	max_sel_t          sel_c;
	logic [COMP_W-1:0] mx_c, mn_c;

	logic [COMP_W-1:0] delta;
	logic [COMP_W:0]   sum;
	logic [COMP_W-1:0] den;
	logic [NUM_W-1:0]  delta_x, six_d, num;
	logic [NUM_W-1:0]  r_x, g_x, b_x;
	logic [HUE_REM_W-1:0] hue_n;
	logic [SAT_REM_W-1:0] sat_n;
	div_word_t         word_c;

	assign stall_s2    = valid_s2 & word_stall;
	assign stall_s1    = valid_s1 & stall_s2;
	assign pixel_stall = stall_s1;

	// stage 1: pick max and min
	always_comb begin
		if (red >= green && red >= blue) begin
			sel_c = MAX_RED;
		end else if (green >= blue) begin
			sel_c = MAX_GREEN;
		end else begin
			sel_c = MAX_BLUE;
		end
		case (sel_c)
			MAX_RED:   mx_c = red;
			MAX_GREEN: mx_c = green;
			MAX_BLUE:  mx_c = blue;
			default:   mx_c = red;
		endcase
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && !stall_s1) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			mx_s1    <= mx_c;
			mn_s1    <= mn_c;
			sel_s1   <= sel_c;
		end
	end

	// stage 2: delta, denominator, hue numerator and scaled dividends
	always_comb begin
		delta   = mx_s1 - mn_s1;
		sum     = {1'b0, mx_s1} + {1'b0, mn_s1};
		den     = (sum < (COMP_W+1)'(255)) ? sum[COMP_W-1:0]
		          : COMP_W'((COMP_W+1)'(510) - sum);
		delta_x = NUM_W'(delta);
		six_d   = (delta_x << 2) + (delta_x << 1);
		r_x     = NUM_W'(red_s1);
		g_x     = NUM_W'(green_s1);
		b_x     = NUM_W'(blue_s1);
		case (sel_s1)
			MAX_RED:   num = g_x - b_x + ((green_s1 < blue_s1) ? six_d : '0);
			MAX_GREEN: num = (delta_x << 1) + b_x - r_x;
			MAX_BLUE:  num = (delta_x << 2) + r_x - g_x;
			default:   num = '0;
		endcase
		hue_n = (HUE_REM_W'(num) << 8) - HUE_REM_W'(num);
		sat_n = (SAT_REM_W'(delta) << 8) - SAT_REM_W'(delta);

		word_c.hue_q     = '0;
		word_c.sat_q     = '0;
		word_c.lightness = sum[COMP_W:1];
		if (delta == '0) begin
			// grey: divide zero by one so both quotients come out zero
			word_c.hue_rem = '0;
			word_c.hue_div = HUE_DIV_W'(1);
			word_c.sat_rem = '0;
			word_c.sat_div = SAT_DIV_W'(1);
		end else begin
			word_c.hue_rem = hue_n;
			word_c.hue_div = six_d;
			word_c.sat_rem = sat_n;
			word_c.sat_div = den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !stall_s2) begin
			word_s2 <= word_c;
		end
	end

	assign word_valid = valid_s2;
	assign word       = word_s2;

endmodule

### hdl/rgb2hsl_divider.sv
module rgb2hsl_divider (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   word_valid,
	output logic                   word_stall,
	input  rgb2hsl_pkg::div_word_t word,
	output logic                   hsl_valid,
	input  logic                   hsl_stall,
	output rgb2hsl_pkg::div_word_t result
);
	import rgb2hsl_pkg::*;

	// One restoring step: take divisor << pos off the remainder if it fits.
	function automatic div_word_t div_step(input div_word_t w, input logic [POS_W-1:0] pos);
		div_word_t            o;
		logic [HUE_REM_W-1:0] hue_sh;
		logic [SAT_REM_W-1:0] sat_sh;
		o      = w;
		hue_sh = HUE_REM_W'(w.hue_div) << pos;
		sat_sh = SAT_REM_W'(w.sat_div) << pos;
		if (w.hue_rem >= hue_sh) begin
			o.hue_rem    = w.hue_rem - hue_sh;
			o.hue_q[pos] = 1'b1;
		end
		if (w.sat_rem >= sat_sh) begin
			o.sat_rem    = w.sat_rem - sat_sh;
			o.sat_q[pos] = 1'b1;
		end
		return o;
	endfunction

	localparam logic [POS_W-1:0] P7 = POS_W'(QUOT_W - 1);
	localparam logic [POS_W-1:0] P6 = POS_W'(QUOT_W - 2);
	localparam logic [POS_W-1:0] P5 = POS_W'(QUOT_W - 3);
	localparam logic [POS_W-1:0] P4 = POS_W'(QUOT_W - 4);
	localparam logic [POS_W-1:0] P3 = POS_W'(QUOT_W - 5);
	localparam logic [POS_W-1:0] P2 = POS_W'(QUOT_W - 6);
	localparam logic [POS_W-1:0] P1 = POS_W'(QUOT_W - 7);
	localparam logic [POS_W-1:0] P0 = POS_W'(QUOT_W - 8);

	logic      valid_s3, valid_s4, valid_s5, valid_s6;
	logic      stall_s3, stall_s4, stall_s5, stall_s6;
	div_word_t word_s3, word_s4, word_s5, word_s6;

	assign stall_s6   = valid_s6 & hsl_stall;
	assign stall_s5   = valid_s5 & stall_s6;
	assign stall_s4   = valid_s4 & stall_s5;
	assign stall_s3   = valid_s3 & stall_s4;
	assign word_stall = stall_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (!stall_s3) valid_s3 <= word_valid;
			if (!stall_s4) valid_s4 <= valid_s3;
			if (!stall_s5) valid_s5 <= valid_s4;
			if (!stall_s6) valid_s6 <= valid_s5;
		end
	end

	// two quotient bits per stage, most significant first
	always_ff @(posedge clk) begin
		if (word_valid && !stall_s3) word_s3 <= div_step(div_step(word, P7), P6);
		if (valid_s3 && !stall_s4)   word_s4 <= div_step(div_step(word_s3, P5), P4);
		if (valid_s4 && !stall_s5)   word_s5 <= div_step(div_step(word_s4, P3), P2);
		if (valid_s5 && !stall_s6)   word_s6 <= div_step(div_step(word_s5, P1), P0);
	end

	assign hsl_valid = valid_s6;
	assign result    = word_s6;

endmodule

### hdl/rgb2hsl_checker.sv
`include "rgb_to_hsl_converter_defines.svh"

module rgb2hsl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pixel_valid,
	input logic                           pixel_stall,
	input logic [rgb2hsl_pkg::COMP_W-1:0] red,
	input logic [rgb2hsl_pkg::COMP_W-1:0] green,
	input logic [rgb2hsl_pkg::COMP_W-1:0] blue,
	input logic                           hsl_valid,
	input logic                           hsl_stall,
	input logic [rgb2hsl_pkg::COMP_W-1:0] hue,
	input logic [rgb2hsl_pkg::COMP_W-1:0] saturation,
	input logic [rgb2hsl_pkg::COMP_W-1:0] lightness
);
	import rgb2hsl_pkg::*;

	// hold a stalled result word
	`RGB2HSL_ASSERT_NEXT(a_out_hold, hsl_valid && hsl_stall, hsl_valid && $stable({hue, saturation, lightness}))
	// input backs up only when the whole pipe is full and the output is stalled
	`RGB2HSL_ASSERT_NOW(a_stall_path, pixel_stall, hsl_valid && hsl_stall)
	// hue never reaches a full turn
	`RGB2HSL_ASSERT_NOW(a_hue_range, hsl_valid, hue != 8'd255)
	// zero saturation only for grey, and grey has zero hue
	`RGB2HSL_ASSERT_NOW(a_grey_hue, hsl_valid && saturation == 8'd0, hue == 8'd0)

endmodule

bind rgb_to_hsl_converter rgb2hsl_checker u_rgb2hsl_checker (.*);
